// File: sv/pi_throttle_regulator_top_assert.svh
// assertion macros for the pi throttle regulator
`ifndef PI_THROTTLE_REGULATOR_TOP_ASSERT_SVH
`define PI_THROTTLE_REGULATOR_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PTR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define PTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ptr_pkg.sv
// types and constants shared by the pi throttle regulator modules
package ptr_pkg;

    localparam int SPEED_W    = 16;
    localparam int GAIN_W     = 16;
    localparam int THROTTLE_W = 15;
    localparam int FRAC_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]     KP_GAIN_RESET      = 16'd33231;
    localparam logic [GAIN_W-1:0]     KI_GAIN_RESET      = 16'd2048;
    localparam logic [THROTTLE_W-1:0] THROTTLE_MAX_RESET = 15'd11520;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN      = 2'd0,
        CFG_KI_GAIN      = 2'd1,
        CFG_THROTTLE_MAX = 2'd2
    } ptr_cfg_idx_t;

    typedef struct packed {
        logic                  going_on;
        logic [SPEED_W-1:0]    cruise_speed;
        logic [SPEED_W-1:0]    vehicle_speed;
    } ptr_in_t;

    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle;
        logic                  clamped;
    } ptr_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0]     kp_gain;
        logic [GAIN_W-1:0]     ki_gain;
        logic [THROTTLE_W-1:0] throttle_max;
    } ptr_cfg_t;

endpackage

// File: sv/pi_throttle_regulator_top.sv
// top level of the pi throttle regulator: input and output registers around the core
//
// Usage:
//   s_ channel carries one sample word (going_on, cruise_speed, vehicle_speed).
//   m_ channel returns one word per sample (throttle, clamped), in order.
//   cfg_ channel writes kp_gain (index 0), ki_gain (1) and throttle_max (2);
//   other indexes are ignored. cfg_ready is always high. Write only when idle.
// Timing:
//   A sample accepted on s_ is captured in the input register, computed
//   combinationally by the core and held in the output register for m_.
//   Throughput is one word per cycle while m_ready is high; the integrator
//   and clamped flag close their loop through the integral multiplier and clamp.
// Reset:
//   Gains and throttle_max take their defaults, the integrator clears and the
//   hold flag is set, so the first sample does not integrate. Both registers
//   empty.
// Stalls:
//   With m_ready low the output word holds; one more sample can wait in the
//   input register, after which s_ready drops until m_ready returns.
`include "pi_throttle_regulator_top_assert.svh"

module pi_throttle_regulator_top
    import ptr_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ptr_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ptr_out_t              m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ptr_cfg_t cfg;
    ptr_in_t  in_reg;
    logic     in_valid_reg;
    ptr_out_t out_reg;
    logic     out_valid_reg;
    ptr_out_t core_out;
    logic     out_en;
    logic     step;
    logic     s_fire;

    ptr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    ptr_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .in_word  (in_reg),
        .cfg      (cfg),
        .out_word (core_out)
    );

    // pipeline flow control
    assign out_en  = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && out_en;
    assign s_ready = !in_valid_reg || out_en;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= core_out;
        end
    end

    // checks on the pipeline control
    `PTR_ASSERT_NEXT(a_step_fills_out, step, out_valid_reg, "computed word did not reach output")
    `PTR_ASSERT_NEXT(a_stall_keeps_in, in_valid_reg && !out_en, in_valid_reg, "stalled word lost")
    `PTR_ASSERT_SAME(a_ready_low_full, !s_ready, in_valid_reg && out_valid_reg, "s_ready low early")

endmodule

// File: sv/ptr_cfg_regs.sv
// configuration register file: gains and throttle limit
module ptr_cfg_regs
    import ptr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cfg_ready,
    output ptr_cfg_t              cfg
);

    ptr_cfg_t cfg_reg;
    ptr_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // decode a write; unknown indexes leave everything as is
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KP_GAIN:      cfg_next.kp_gain      = cfg_data;
                CFG_KI_GAIN:      cfg_next.ki_gain      = cfg_data;
                CFG_THROTTLE_MAX: cfg_next.throttle_max = cfg_data[THROTTLE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain      <= KP_GAIN_RESET;
            cfg_reg.ki_gain      <= KI_GAIN_RESET;
            cfg_reg.throttle_max <= THROTTLE_MAX_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: sv/ptr_core.sv
// pi datapath with clamping anti-windup and the integrator state
module ptr_core
    import ptr_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  ptr_in_t  in_word,
    input  ptr_cfg_t cfg,
    output ptr_out_t out_word
);

    localparam int ERR_W  = SPEED_W + 1;
    localparam int PT_W   = ERR_W + GAIN_W;
    localparam int IT_W   = ACC_WIDTH + GAIN_W + 1;
    localparam int SUM_W  = IT_W + 1;

    logic signed [ACC_WIDTH-1:0] integral_reg;
    logic signed [ACC_WIDTH-1:0] integral_next;
    logic                        last_clamped_reg;
    logic                        last_clamped_next;

    logic signed [ERR_W-1:0]     err;
    logic signed [PT_W-1:0]      p_term;
    logic signed [IT_W-1:0]      i_term;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     limit;
    logic signed [ACC_WIDTH:0]   acc_wide;
    logic signed [ACC_WIDTH-1:0] acc_sat;
    logic signed [ACC_WIDTH-1:0] acc_base;
    logic                        hold;

    // speed error, signed q8.8
    assign err = $signed({1'b0, in_word.cruise_speed}) - $signed({1'b0, in_word.vehicle_speed});

    // integrator: cleared on going on, held while the last command was clamped
    assign acc_base = in_word.going_on ? '0 : integral_reg;
    assign hold     = in_word.going_on | last_clamped_reg;
    assign acc_wide = {acc_base[ACC_WIDTH-1], acc_base}
                    + {{(ACC_WIDTH + 1 - ERR_W){err[ERR_W-1]}}, err};

    // saturate the accumulator at its signed limits
    always_comb begin
        if (acc_wide[ACC_WIDTH] != acc_wide[ACC_WIDTH-1]) begin
            acc_sat = acc_wide[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                          : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        end else begin
            acc_sat = acc_wide[ACC_WIDTH-1:0];
        end
    end

    assign integral_next = hold ? acc_base : acc_sat;

    // proportional and integral products, q.20
    assign p_term = err * $signed({1'b0, cfg.kp_gain});
    assign i_term = integral_next * $signed({1'b0, cfg.ki_gain});
    assign sum    = SUM_W'(p_term) + SUM_W'(i_term);
    assign limit  = $signed(SUM_W'({1'b0, cfg.throttle_max, {FRAC_W{1'b0}}}));

    // clamp to zero .. throttle_max
    always_comb begin
        priority if (sum > limit) begin
            out_word.throttle = cfg.throttle_max;
            out_word.clamped  = 1'b1;
        end else if (sum[SUM_W-1]) begin
            out_word.throttle = '0;
            out_word.clamped  = 1'b1;
        end else begin
            out_word.throttle = sum[FRAC_W +: THROTTLE_W];
            out_word.clamped  = 1'b0;
        end
    end

    assign last_clamped_next = out_word.clamped;

    // state advances only when a word moves to the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg     <= '0;
            last_clamped_reg <= 1'b1;
        end else if (step) begin
            integral_reg     <= integral_next;
            last_clamped_reg <= last_clamped_next;
        end
    end

endmodule

// File: tb/testbench.sv
// self-checking testbench for the pi throttle regulator top level
`timescale 1ns / 1ps

module testbench;
    import ptr_pkg::*;

    localparam int ACC_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int LONG_STALL = 300;
    localparam int SAT_RUN = 12;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    ptr_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ptr_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // controller state mirrored by the checker
    logic [GAIN_W-1:0] kp_r = KP_GAIN_RESET;
    logic [GAIN_W-1:0] ki_r = KI_GAIN_RESET;
    logic [THROTTLE_W-1:0] tmax_r = THROTTLE_MAX_RESET;
    logic signed [ACC_W-1:0] integ_acc = '0;
    logic hold_next = 1'b1;

    ptr_in_t sample_queue[$];
    ptr_out_t throttle_due[$];
    ptr_out_t want_word;

    int err_count = 0;
    int tx_gap_max = 0;
    int rx_gap_max = 0;
    int tx_wait = 0;
    int rx_wait = 0;
    int rx_draw;
    int long_left = 0;
    logic long_req = 1'b0;
    logic long_done = 1'b0;

    // state of the well-formed drive sequence
    int run_left = 0;
    logic [SPEED_W-1:0] run_cruise = '0;

    pi_throttle_regulator_top #(
        .ACC_WIDTH(ACC_W)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // pi step with clamping anti-windup, returns the expected command
    function automatic ptr_out_t regulate(ptr_in_t smp);
        logic signed [17:0] err;
        logic signed [63:0] p_term;
        logic signed [63:0] i_term;
        logic signed [63:0] total;
        logic signed [63:0] ceiling;
        logic signed [63:0] wide;
        logic signed [63:0] acc_hi;
        logic signed [63:0] acc_lo;
        logic hold;
        ptr_out_t res;
        acc_hi = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
        acc_lo = -acc_hi - 64'sd1;
        hold = hold_next;
        if (smp.going_on) begin
            integ_acc = '0;
            hold = 1'b1;
        end
        err = $signed({2'b00, smp.cruise_speed}) - $signed({2'b00, smp.vehicle_speed});
        p_term = err * $signed({48'd0, kp_r});
        // accumulator saturates at its signed width
        if (!hold) begin
            wide = integ_acc + err;
            if (wide > acc_hi)
                wide = acc_hi;
            else if (wide < acc_lo)
                wide = acc_lo;
            integ_acc = wide[ACC_W-1:0];
        end
        i_term = integ_acc * $signed({48'd0, ki_r});
        total = p_term + i_term;
        ceiling = $signed({37'd0, tmax_r, 12'd0});
        if (total > ceiling) begin
            res.throttle = tmax_r;
            res.clamped = 1'b1;
        end else if (total < 0) begin
            res.throttle = '0;
            res.clamped = 1'b1;
        end else begin
            res.throttle = total[THROTTLE_W+FRAC_W-1:FRAC_W];
            res.clamped = 1'b0;
        end
        hold_next = res.clamped;
        return res;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic void queue_sample(logic g, logic [SPEED_W-1:0] c,
                                         logic [SPEED_W-1:0] v);
        ptr_in_t smp;
        smp.going_on = g;
        smp.cruise_speed = c;
        smp.vehicle_speed = v;
        sample_queue.push_back(smp);
    endfunction

    // mostly drive runs that start with going on, some pure noise
    function automatic ptr_in_t draw_sample();
        ptr_in_t smp;
        int v;
        if ($urandom_range(0, 4) == 0) begin
            smp.going_on = 1'($urandom_range(0, 1));
            smp.cruise_speed = 16'($urandom);
            smp.vehicle_speed = 16'($urandom);
        end else begin
            if (run_left == 0) begin
                run_left = $urandom_range(5, 40);
                run_cruise = 16'($urandom);
                smp.going_on = 1'b1;
            end else begin
                smp.going_on = 1'b0;
            end
            run_left--;
            v = int'(run_cruise) + $urandom_range(0, 2047) - 1024;
            if (v < 0)
                v = 0;
            if (v > 65535)
                v = 65535;
            smp.cruise_speed = run_cruise;
            smp.vehicle_speed = v[SPEED_W-1:0];
        end
        return smp;
    endfunction

    // one register write; valid is left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        case (idx)
            CFG_KP_GAIN: kp_r = val;
            CFG_KI_GAIN: ki_r = val;
            CFG_THROTTLE_MAX: tmax_r = val[THROTTLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] kp, logic [CFG_DATA_W-1:0] ki,
                             logic [CFG_DATA_W-1:0] tmax);
        write_reg(CFG_KP_GAIN, kp);
        write_reg(CFG_KI_GAIN, ki);
        write_reg(CFG_THROTTLE_MAX, tmax);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued word went in and every expected word came out
    task automatic settle();
        while (sample_queue.size() != 0 || s_valid || throttle_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // sample driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait <= 0;
        end else if (!s_valid || s_ready) begin
            if (tx_wait > 0) begin
                s_valid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (sample_queue.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= sample_queue.pop_front();
                tx_wait <= $urandom_range(0, tx_gap_max);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted samples, check returned words, pace m_ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
            long_left <= 0;
        end else begin
            if (s_valid && s_ready)
                throttle_due.push_back(regulate(s_data));
            if (m_valid && m_ready) begin
                if (throttle_due.size() == 0) begin
                    flag_mismatch("unexpected word, throttle", m_data.throttle, 0);
                end else begin
                    want_word = throttle_due.pop_front();
                    if (m_data.throttle !== want_word.throttle)
                        flag_mismatch("throttle", m_data.throttle, want_word.throttle);
                    if (m_data.clamped !== want_word.clamped)
                        flag_mismatch("clamped", m_data.clamped, want_word.clamped);
                end
            end
            // ready pacing, with one long hold-off on request
            if (long_left > 0) begin
                long_left <= long_left - 1;
                m_ready <= (long_left == 1);
            end else if (long_req && !long_done) begin
                long_done <= 1'b1;
                long_left <= LONG_STALL;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready) begin
                rx_draw = $urandom_range(0, rx_gap_max);
                rx_wait <= rx_draw;
                m_ready <= (rx_draw == 0);
            end else if (rx_wait > 0) begin
                rx_wait <= rx_wait - 1;
                m_ready <= (rx_wait == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus sequence
    initial begin
        int ph;
        int k;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed samples at reset gains
        tx_gap_max = 10;
        rx_gap_max = 10;
        queue_sample(1'b1, 16'd25600, 16'd25600);
        queue_sample(1'b0, 16'd25600, 16'd25344);
        queue_sample(1'b0, 16'd25600, 16'd25344);
        queue_sample(1'b0, 16'd25600, 16'd25344);
        queue_sample(1'b0, 16'd0, 16'hFFFF);
        queue_sample(1'b0, 16'hFFFF, 16'd0);
        queue_sample(1'b0, 16'hFFFF, 16'hFFFF);
        queue_sample(1'b0, 16'd0, 16'd0);
        queue_sample(1'b1, 16'hFFFF, 16'd0);
        queue_sample(1'b0, 16'h8000, 16'h7FFF);
        queue_sample(1'b0, 16'h7FFF, 16'h8000);
        queue_sample(1'b0, 16'hAAAA, 16'h5555);
        queue_sample(1'b0, 16'h5555, 16'hAAAA);
        queue_sample(1'b1, 16'd30000, 16'd29000);
        for (k = 1; k <= 8; k++)
            queue_sample(1'b0, 16'd30000, 16'(30000 - 64 * k));
        queue_sample(1'b1, 16'd30000, 16'd30100);
        queue_sample(1'b0, 16'd30000, 16'd30100);
        settle();

        // random phases over several gain and limit settings
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    tx_gap_max = 10;
                    rx_gap_max = 10;
                    configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                1: begin
                    tx_gap_max = 0;
                    rx_gap_max = 0;
                    configure(16'd0, 16'd0, 16'd0);
                end
                2: begin
                    tx_gap_max = 10;
                    rx_gap_max = 0;
                    write_reg(CFG_SPARE, 16'($urandom));
                    configure(KP_GAIN_RESET, KI_GAIN_RESET, 16'(THROTTLE_MAX_RESET));
                end
                3: begin
                    tx_gap_max = 0;
                    rx_gap_max = 10;
                    configure(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                              16'd25600);
                end
                4: begin
                    tx_gap_max = 0;
                    rx_gap_max = 3;
                    configure(16'($urandom), 16'($urandom_range(0, 4095)),
                              16'($urandom_range(1, 25600)));
                    long_req <= 1'b1;
                end
                default: begin
                    tx_gap_max = 10;
                    rx_gap_max = 10;
                    configure(16'($urandom), 16'($urandom), 16'($urandom));
                end
            endcase
            for (k = 0; k < 255; k++)
                sample_queue.push_back(draw_sample());
            settle();
        end

        // build up a large positive integrator with no output gain
        tx_gap_max = 0;
        rx_gap_max = 0;
        configure(16'd0, 16'd0, 16'h7FFF);
        queue_sample(1'b1, 16'd0, 16'd0);
        for (k = 0; k < SAT_RUN; k++)
            queue_sample(1'b0, 16'hFFFF, 16'($urandom_range(0, 1500)));
        settle();
        configure(16'd32768, 16'd1, 16'h7FFF);
        queue_sample(1'b0, 16'd0, 16'hFFFF);
        queue_sample(1'b0, 16'd0, 16'hFFFF);
        queue_sample(1'b0, 16'd100, 16'd90);
        settle();

        // and a large negative one
        configure(16'd0, 16'd0, 16'h7FFF);
        queue_sample(1'b1, 16'd0, 16'd0);
        for (k = 0; k < SAT_RUN; k++)
            queue_sample(1'b0, 16'($urandom_range(0, 1500)), 16'hFFFF);
        settle();
        configure(16'd32769, 16'd1, 16'h7FFF);
        queue_sample(1'b0, 16'hFFFF, 16'd0);
        queue_sample(1'b0, 16'hFFFF, 16'd0);
        queue_sample(1'b0, 16'd90, 16'd100);
        settle();

        repeat (10) @(posedge aclk);
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/ptr_pkg.sv
sv/ptr_cfg_regs.sv
sv/ptr_core.sv
sv/pi_throttle_regulator_top.sv
tb/testbench.sv
